FILE: rtl/linear_array_deque_macros.svh
`ifndef LINEAR_ARRAY_DEQUE_MACROS_SVH
`define LINEAR_ARRAY_DEQUE_MACROS_SVH

// Implication checked at every edge outside reset.
`define LAD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, also checked during reset.
`define LAD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lad_pkg.sv
`default_nettype none
package lad_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int DATA_WIDTH  = 32;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CMDQ_DEPTH  = 2;
  localparam int CMDQ_AW     = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW     = $clog2(CMDQ_DEPTH + 1);

  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic signed [DATA_WIDTH-1:0] data_t;

  typedef enum logic [2:0] {
    REQ_INS_REAR  = 3'd0,
    REQ_INS_FRONT = 3'd1,
    REQ_DEL_REAR  = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_LIST      = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_OVERFLOW     = 2'd1,
    ST_EMPTY        = 2'd2,
    ST_NOT_POSSIBLE = 2'd3
  } status_t;

  typedef enum logic {
    BK_IDLE,
    BK_LIST
  } back_st_t;

  typedef struct packed {
    req_t  op;
    data_t item;
  } cmd_t;

endpackage
`default_nettype wire

FILE: rtl/lad_in_if.sv
`default_nettype none
interface lad_in_if;
  logic                  valid;
  logic                  ready;
  logic [2:0]            req_type;
  lad_pkg::data_t        item;

  modport source (output valid, output req_type, output item, input ready);
  modport sink   (input valid, input req_type, input item, output ready);
endinterface
`default_nettype wire

FILE: rtl/lad_out_if.sv
`default_nettype none
interface lad_out_if;
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  lad_pkg::data_t        data;
  logic                  last;

  modport source (output valid, output status, output data, output last, input ready);
  modport sink   (input valid, input status, input data, input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/linear_array_deque.sv
// Array deque of lad_pkg::QUEUE_DEPTH signed words, non-circular.
// in_ch:  request word (req_type, item); taken on valid && ready.
//         Codes 0..3 insert/delete at rear/front, 4 lists; codes 5..7 are
//         taken and dropped without a result.
// out_ch: result word (status, data, last); last marks a request's final word.
// A front stage checks the code and pushes the request into a two-entry
// command queue; the back stage owns the storage and the end pointers and
// drives a single output register.
// The request is registered in the command queue and then, once the back
// stage takes it, in the output register that drives the result word.
// Throughput: one insert or delete request per cycle is sustained while
// out_ch.ready stays high; a listing holds the back stage while it sends its
// entries, one entry per cycle from the storage read port while out_ch.ready
// is high, and in_ch keeps taking requests until the command queue is full.
// Reset: queue empty, both ends at slot zero, no result pending, command
// queue flushed. Storage contents are not cleared.
// Stall: with out_ch.ready low the result word holds, the back stage stops,
// and in_ch.ready drops once the command queue fills.
`default_nettype none
module linear_array_deque (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lad_in_if.sink      in_ch,
  lad_out_if.source   out_ch
);

  logic           q_push;
  logic           q_full;
  lad_pkg::cmd_t  q_in_cmd;
  logic           q_pop;
  logic           q_valid;
  lad_pkg::cmd_t  q_out_cmd;

  lad_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_in_cmd)
  );

  lad_cmd_fifo u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_in_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_cmd   (q_out_cmd)
  );

  lad_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (q_out_cmd),
    .cmd_pop   (q_pop),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

FILE: rtl/lad_front.sv
`default_nettype none
module lad_front (
  lad_in_if.sink        in_ch,
  input  wire logic     q_full,
  output logic          q_push,
  output lad_pkg::cmd_t q_cmd
);

  logic code_ok;

  always_comb begin
    case (lad_pkg::req_t'(in_ch.req_type))
      lad_pkg::REQ_INS_REAR,
      lad_pkg::REQ_INS_FRONT,
      lad_pkg::REQ_DEL_REAR,
      lad_pkg::REQ_DEL_FRONT,
      lad_pkg::REQ_LIST: code_ok = 1'b1;
      default:           code_ok = 1'b0;
    endcase
  end

  // drop unused codes at the door
  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full && code_ok;
  assign q_cmd.op    = lad_pkg::req_t'(in_ch.req_type);
  assign q_cmd.item  = in_ch.item;

endmodule
`default_nettype wire

FILE: rtl/lad_cmd_fifo.sv
`default_nettype none
module lad_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire lad_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               pop_valid,
  output lad_pkg::cmd_t      pop_cmd
);

  lad_pkg::cmd_t                   slot_r [lad_pkg::CMDQ_DEPTH];
  logic [lad_pkg::CMDQ_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [lad_pkg::CMDQ_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [lad_pkg::CMDQ_CW-1:0]     count_r, count_nxt;
  logic                            do_push, do_pop;

  assign full      = (count_r == lad_pkg::CMDQ_CW'(lad_pkg::CMDQ_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_cmd   = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == lad_pkg::CMDQ_AW'(lad_pkg::CMDQ_DEPTH - 1)) ? '0
                   : wr_ptr_r + lad_pkg::CMDQ_AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == lad_pkg::CMDQ_AW'(lad_pkg::CMDQ_DEPTH - 1)) ? '0
                   : rd_ptr_r + lad_pkg::CMDQ_AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + lad_pkg::CMDQ_CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - lad_pkg::CMDQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lad_back.sv
`default_nettype none
module lad_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  input  wire lad_pkg::cmd_t cmd,
  output logic               cmd_pop,
  lad_out_if.source          out_ch
);

  lad_pkg::data_t     mem [lad_pkg::QUEUE_DEPTH];

  lad_pkg::back_st_t  st_r, st_nxt;
  lad_pkg::idx_t      front_r, front_nxt;
  lad_pkg::idx_t      rear_r, rear_nxt;
  lad_pkg::idx_t      list_idx_r, list_idx_nxt;
  logic               empty_r, empty_nxt;

  logic               out_valid_r;
  lad_pkg::status_t   out_status_r;
  lad_pkg::data_t     out_data_r;
  logic               out_last_r;

  logic               can_load;
  logic               load;
  logic               mem_rd;
  lad_pkg::idx_t      rd_addr;
  logic               wr_en;
  lad_pkg::idx_t      wr_addr;
  lad_pkg::status_t   res_status;
  logic               res_last;

  localparam lad_pkg::idx_t IdxTop = lad_pkg::idx_t'(lad_pkg::QUEUE_DEPTH - 1);

  assign can_load = !out_valid_r || out_ch.ready;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      lad_pkg::BK_IDLE: begin
        if (cmd_valid && can_load && cmd.op == lad_pkg::REQ_LIST && !empty_r &&
            front_r != rear_r) begin
          st_nxt = lad_pkg::BK_LIST;
        end
      end
      lad_pkg::BK_LIST: begin
        if (can_load && list_idx_r == rear_r) begin
          st_nxt = lad_pkg::BK_IDLE;
        end
      end
      default: st_nxt = lad_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop      = 1'b0;
    load         = 1'b0;
    mem_rd       = 1'b0;
    rd_addr      = front_r;
    wr_en        = 1'b0;
    wr_addr      = '0;
    res_status   = lad_pkg::ST_OK;
    res_last     = 1'b1;
    front_nxt    = front_r;
    rear_nxt     = rear_r;
    empty_nxt    = empty_r;
    list_idx_nxt = list_idx_r;
    case (st_r)
      lad_pkg::BK_IDLE: begin
        if (cmd_valid && can_load) begin
          cmd_pop = 1'b1;
          load    = 1'b1;
          case (cmd.op)
            lad_pkg::REQ_INS_REAR: begin
              if (empty_r) begin
                wr_en     = 1'b1;
                front_nxt = '0;
                rear_nxt  = '0;
                empty_nxt = 1'b0;
              end else if (rear_r == IdxTop) begin
                res_status = lad_pkg::ST_OVERFLOW;
              end else begin
                wr_en    = 1'b1;
                wr_addr  = rear_r + lad_pkg::idx_t'(1);
                rear_nxt = rear_r + lad_pkg::idx_t'(1);
              end
            end
            lad_pkg::REQ_INS_FRONT: begin
              if (empty_r) begin
                wr_en     = 1'b1;
                front_nxt = '0;
                rear_nxt  = '0;
                empty_nxt = 1'b0;
              end else if (front_r != '0) begin
                wr_en     = 1'b1;
                wr_addr   = front_r - lad_pkg::idx_t'(1);
                front_nxt = front_r - lad_pkg::idx_t'(1);
              end else begin
                res_status = lad_pkg::ST_NOT_POSSIBLE;
              end
            end
            lad_pkg::REQ_DEL_REAR: begin
              if (empty_r) begin
                res_status = lad_pkg::ST_EMPTY;
              end else begin
                mem_rd  = 1'b1;
                rd_addr = rear_r;
                if (rear_r == front_r) begin
                  front_nxt = '0;
                  rear_nxt  = '0;
                  empty_nxt = 1'b1;
                end else begin
                  rear_nxt = rear_r - lad_pkg::idx_t'(1);
                end
              end
            end
            lad_pkg::REQ_DEL_FRONT: begin
              if (empty_r) begin
                res_status = lad_pkg::ST_EMPTY;
              end else begin
                mem_rd  = 1'b1;
                rd_addr = front_r;
                if (rear_r == front_r) begin
                  front_nxt = '0;
                  rear_nxt  = '0;
                  empty_nxt = 1'b1;
                end else begin
                  front_nxt = front_r + lad_pkg::idx_t'(1);
                end
              end
            end
            lad_pkg::REQ_LIST: begin
              if (empty_r) begin
                res_status = lad_pkg::ST_EMPTY;
              end else begin
                mem_rd       = 1'b1;
                rd_addr      = front_r;
                res_last     = (front_r == rear_r);
                list_idx_nxt = front_r + lad_pkg::idx_t'(1);
              end
            end
            default: begin
              load = 1'b0;
            end
          endcase
        end
      end
      lad_pkg::BK_LIST: begin
        if (can_load) begin
          load         = 1'b1;
          mem_rd       = 1'b1;
          rd_addr      = list_idx_r;
          res_last     = (list_idx_r == rear_r);
          list_idx_nxt = list_idx_r + lad_pkg::idx_t'(1);
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= lad_pkg::BK_IDLE;
      front_r     <= '0;
      rear_r      <= '0;
      empty_r     <= 1'b1;
      list_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      front_r     <= front_nxt;
      rear_r      <= rear_nxt;
      empty_r     <= empty_nxt;
      list_idx_r  <= list_idx_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.item;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= res_status;
      out_last_r   <= res_last;
      out_data_r   <= mem_rd ? mem[rd_addr] : '0;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.data   = out_data_r;
  assign out_ch.last   = out_last_r;

endmodule
`default_nettype wire

FILE: rtl/lad_checker.sv
`default_nettype none
`include "linear_array_deque_macros.svh"
module lad_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [1:0]           out_status,
  input wire lad_pkg::data_t       out_data,
  input wire logic                 out_last
);

  `LAD_ASSERT_NEXT(a_reset_idle, !rst_n, !out_valid, "result word valid after reset")
  `LAD_ASSERT_IMP(a_valid_hold, out_valid && !out_ready, ##1 out_valid, "result word dropped")
  `LAD_ASSERT_IMP(a_err_last, out_valid && out_status != lad_pkg::ST_OK, out_last, "error word not last")
  `LAD_ASSERT_IMP(a_err_zero, out_valid && out_status != lad_pkg::ST_OK, out_data == '0, "error word carries data")

endmodule

bind linear_array_deque lad_checker u_lad_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_data   (out_ch.data),
  .out_last   (out_ch.last)
);
`default_nettype wire

FILE: sim/linear_array_deque_test.sv
`default_nettype none
module linear_array_deque_test;

  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         RANDOM_WORDS = 190;
  localparam int         DRAIN_CYCLES = 24;
  localparam int         HOLD_CYCLES  = 120;
  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  typedef struct {
    logic [2:0]     code;
    lad_pkg::data_t item;
  } req_word_t;

  typedef struct {
    lad_pkg::status_t status;
    lad_pkg::data_t   data;
    logic             last;
  } result_word_t;

  logic clk;
  logic rst_n;

  lad_in_if  in_ch ();
  lad_out_if out_ch ();

  linear_array_deque dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  req_word_t    req_words[$];
  result_word_t results_due[$];

  lad_pkg::data_t dq_slots [lad_pkg::QUEUE_DEPTH];
  lad_pkg::idx_t  dq_front;
  lad_pkg::idx_t  dq_rear;
  logic           dq_empty;

  int   mismatches;
  int   words_taken;
  int   cycles;
  logic word_taken;
  logic hold_off;
  int   gap_left;
  int   burst_left;
  logic [15:0] stall_pat;
  int   pat_age;

  always begin
    #4 clk = ~clk;
  end

  task automatic owe(input lad_pkg::status_t s, input lad_pkg::data_t d, input logic l);
    result_word_t r;
    r.status = s;
    r.data   = d;
    r.last   = l;
    results_due.push_back(r);
  endtask

  task automatic deque_predict(input logic [2:0] code, input lad_pkg::data_t value);
    case (code)
      lad_pkg::REQ_INS_REAR, lad_pkg::REQ_INS_FRONT: begin
        if (dq_empty) begin
          dq_slots[0] = value;
          dq_front    = '0;
          dq_rear     = '0;
          dq_empty    = 1'b0;
          owe(lad_pkg::ST_OK, '0, 1'b1);
        end else if (code == lad_pkg::REQ_INS_REAR) begin
          if (dq_rear == lad_pkg::idx_t'(lad_pkg::QUEUE_DEPTH - 1)) begin
            owe(lad_pkg::ST_OVERFLOW, '0, 1'b1);
          end else begin
            dq_rear           = dq_rear + lad_pkg::idx_t'(1);
            dq_slots[dq_rear] = value;
            owe(lad_pkg::ST_OK, '0, 1'b1);
          end
        end else if (dq_front != '0) begin
          dq_front           = dq_front - lad_pkg::idx_t'(1);
          dq_slots[dq_front] = value;
          owe(lad_pkg::ST_OK, '0, 1'b1);
        end else begin
          owe(lad_pkg::ST_NOT_POSSIBLE, '0, 1'b1);
        end
      end
      lad_pkg::REQ_DEL_REAR, lad_pkg::REQ_DEL_FRONT: begin
        if (dq_empty) begin
          owe(lad_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          owe(lad_pkg::ST_OK,
              dq_slots[(code == lad_pkg::REQ_DEL_REAR) ? dq_rear : dq_front], 1'b1);
          if (dq_rear == dq_front) begin
            dq_front = '0;
            dq_rear  = '0;
            dq_empty = 1'b1;
          end else if (code == lad_pkg::REQ_DEL_REAR) begin
            dq_rear = dq_rear - lad_pkg::idx_t'(1);
          end else begin
            dq_front = dq_front + lad_pkg::idx_t'(1);
          end
        end
      end
      lad_pkg::REQ_LIST: begin
        if (dq_empty) begin
          owe(lad_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = dq_front; i <= dq_rear; i++) begin
            owe(lad_pkg::ST_OK, dq_slots[lad_pkg::idx_t'(i)], (i == dq_rear));
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic note_mismatch(input string what, input result_word_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: want status %0d data %0d last %0d, got status %0d data %0d last %0d",
               what, want.status, want.data, want.last,
               out_ch.status, out_ch.data, out_ch.last);
    end
  endtask

  // check the result word first, then predict from the request word
  always @(posedge clk) begin
    result_word_t want;
    word_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          want.status = lad_pkg::ST_OK;
          want.data   = '0;
          want.last   = 1'b0;
          note_mismatch("unexpected word", want);
        end else begin
          want = results_due.pop_front();
          if (out_ch.status !== want.status || out_ch.data !== want.data ||
              out_ch.last !== want.last) begin
            note_mismatch("mismatch", want);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        deque_predict(in_ch.req_type, in_ch.item);
        void'(req_words.pop_front());
        words_taken++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[linear_array_deque] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !word_taken) begin
      // hold until taken
    end else if (gap_left != 0 || req_words.size() == 0) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end
      in_ch.valid    <= 1'b0;
      in_ch.req_type <= 3'($urandom);
      in_ch.item     <= lad_pkg::data_t'($urandom);
    end else begin
      in_ch.valid    <= 1'b1;
      in_ch.req_type <= req_words[0].code;
      in_ch.item     <= req_words[0].item;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 30);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && stall_pat[0];
      if (pat_age == 63) begin
        pat_age <= 0;
        case ($urandom_range(0, 3))
          0:       stall_pat <= 16'hffff;
          1:       stall_pat <= 16'($urandom) | 16'h0001;
          2:       stall_pat <= 16'($urandom | $urandom) | 16'h0001;
          default: stall_pat <= 16'($urandom & $urandom) | 16'h0001;
        endcase
      end else begin
        pat_age   <= pat_age + 1;
        stall_pat <= {stall_pat[0], stall_pat[15:1]};
      end
    end
  end

  // hold off the receiver long enough to fill the command queue
  initial begin
    hold_off = 1'b0;
    wait (words_taken >= 60);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  task automatic add_word(input logic [2:0] code, input lad_pkg::data_t value);
    req_word_t w;
    w.code = code;
    w.item = value;
    req_words.push_back(w);
  endtask

  function automatic lad_pkg::data_t pick_item();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return -32'sd1;
      3:       return '0;
      default: return lad_pkg::data_t'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] pick_op(input int bias);
    int            r;
    lad_pkg::req_t op;
    r = $urandom_range(0, 99);
    case (bias)
      0:       op = r < 55 ? lad_pkg::REQ_INS_REAR : r < 70 ? lad_pkg::REQ_INS_FRONT :
                    r < 80 ? lad_pkg::REQ_DEL_FRONT : r < 90 ? lad_pkg::REQ_DEL_REAR :
                    lad_pkg::REQ_LIST;
      1:       op = r < 45 ? lad_pkg::REQ_DEL_FRONT : r < 75 ? lad_pkg::REQ_INS_FRONT :
                    r < 85 ? lad_pkg::REQ_INS_REAR : r < 93 ? lad_pkg::REQ_DEL_REAR :
                    lad_pkg::REQ_LIST;
      2:       op = r < 40 ? lad_pkg::REQ_DEL_REAR : r < 65 ? lad_pkg::REQ_DEL_FRONT :
                    r < 80 ? lad_pkg::REQ_INS_REAR : r < 90 ? lad_pkg::REQ_INS_FRONT :
                    lad_pkg::REQ_LIST;
      default: op = r < 25 ? lad_pkg::REQ_INS_REAR : r < 45 ? lad_pkg::REQ_INS_FRONT :
                    r < 62 ? lad_pkg::REQ_DEL_REAR : r < 79 ? lad_pkg::REQ_DEL_FRONT :
                    lad_pkg::REQ_LIST;
    endcase
    return op;
  endfunction

  initial begin
    int counted;
    int bias;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = '0;
    in_ch.item     = '0;
    out_ch.ready   = 1'b0;
    mismatches     = 0;
    words_taken    = 0;
    cycles         = 0;
    word_taken     = 1'b0;
    gap_left       = 0;
    burst_left     = 1;
    stall_pat      = 16'hffff;
    pat_age        = 0;
    dq_front       = '0;
    dq_rear        = '0;
    dq_empty       = 1'b1;

    add_word(lad_pkg::REQ_LIST, '0);
    add_word(lad_pkg::REQ_DEL_REAR, '0);
    add_word(lad_pkg::REQ_DEL_FRONT, '0);
    add_word(lad_pkg::REQ_INS_FRONT, 32'sh7fffffff);
    add_word(lad_pkg::REQ_INS_FRONT, 32'sh00000001);
    add_word(lad_pkg::REQ_DEL_REAR, '0);
    add_word(lad_pkg::REQ_INS_REAR, 32'sh80000000);
    add_word(lad_pkg::REQ_INS_REAR, -32'sd1);
    add_word(lad_pkg::REQ_INS_REAR, '0);
    add_word(lad_pkg::REQ_INS_REAR, 32'sh00000001);
    add_word(lad_pkg::REQ_INS_REAR, 32'sh55555555);
    add_word(lad_pkg::REQ_INS_REAR, 32'shaaaaaaaa);
    add_word(lad_pkg::REQ_INS_REAR, 32'sh0000ffff);
    add_word(lad_pkg::REQ_INS_REAR, 32'shffff0000);
    add_word(lad_pkg::REQ_INS_REAR, 32'sh12345678);
    add_word(lad_pkg::REQ_LIST, '0);
    add_word(lad_pkg::REQ_DEL_FRONT, '0);
    add_word(lad_pkg::REQ_DEL_FRONT, '0);
    add_word(lad_pkg::REQ_INS_FRONT, 32'sh7fffffff);
    add_word(lad_pkg::REQ_INS_REAR, 32'sh80000000);
    add_word(REQ_UNUSED_LO, 32'sh7fffffff);
    add_word(REQ_UNUSED_LO + 3'd1, -32'sd1);
    add_word(REQ_UNUSED_HI, 32'sh80000000);
    add_word(lad_pkg::REQ_DEL_REAR, '0);

    // phases of fill, drain and mix keep both ends moving
    counted = 0;
    bias    = 0;
    while (counted < RANDOM_WORDS) begin
      if (counted % 16 == 0) begin
        bias = $urandom_range(0, 3);
      end
      if ($urandom_range(0, 99) < 3) begin
        add_word(3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)), pick_item());
      end else begin
        add_word(pick_op(bias), pick_item());
        counted++;
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (req_words.size() != 0) @(negedge clk);
    while (results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    mismatches += results_due.size();
    if (mismatches == 0) begin
      $display("[linear_array_deque] OK");
    end else begin
      $display("[linear_array_deque] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: linear_array_deque.f
+incdir+rtl
rtl/lad_pkg.sv
rtl/lad_in_if.sv
rtl/lad_out_if.sv
rtl/lad_front.sv
rtl/lad_cmd_fifo.sv
rtl/lad_back.sv
rtl/linear_array_deque.sv
rtl/lad_checker.sv
sim/linear_array_deque_test.sv
